// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file ssa_checker.sv.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== design/ssa_pkg.sv =====
// Shared types and constants for the segment sum accumulator.
// No dependencies; the files that use it refer to this package by scoped names.
package ssa_pkg;

  localparam int CMD_W    = 2;
  localparam int SEG_W    = 32;
  localparam int COL_W    = 8;
  localparam int VAL_W    = 32;
  localparam int SUM_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'd1;

  localparam logic [CFG_W-1:0] SEG_COUNT_RST = 5'd16;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SEG_ERR = 2'd1,
    ST_COL_ERR = 2'd2
  } status_t;

  // Decoded command as handed from the front end to the pipeline.
  typedef struct packed {
    cmd_t    cmd;
    status_t status;
  } decode_t;

endpackage

// ===== design/ssa_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on ssa_pkg for field widths and the command type.
interface ssa_req_if;
  logic                            valid;
  logic                            ready;
  ssa_pkg::cmd_t                   cmd;
  logic signed [ssa_pkg::SEG_W-1:0] segment_id;
  logic        [ssa_pkg::COL_W-1:0] column;
  logic signed [ssa_pkg::VAL_W-1:0] value;

  modport source (output valid, cmd, segment_id, column, value, input ready);
  modport sink   (input valid, cmd, segment_id, column, value, output ready);
  modport mon    (input valid, ready, cmd, segment_id, column, value);
endinterface

interface ssa_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ssa_pkg::SUM_W-1:0]    sum;
  logic        [ssa_pkg::STATUS_W-1:0] status;
  logic                               error_seen;

  modport source (output valid, sum, status, error_seen, input ready);
  modport sink   (input valid, sum, status, error_seen, output ready);
  modport mon    (input valid, ready, sum, status, error_seen);
endinterface

// ===== design/ssa_decode.sv =====
// Command front end: range checks on segment and column, and the table address.
// Depends on ssa_pkg.
module ssa_decode #(
  parameter int MAX_SEGMENTS  = 16,
  parameter int MAX_ROW_WIDTH = 16,
  localparam int DEPTH  = MAX_SEGMENTS * MAX_ROW_WIDTH,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  ssa_pkg::cmd_t                    cmd,
  input  logic signed [ssa_pkg::SEG_W-1:0] segment_id,
  input  logic        [ssa_pkg::COL_W-1:0] column,
  input  logic        [ssa_pkg::CFG_W-1:0] seg_count,
  input  logic        [ssa_pkg::CFG_W-1:0] row_width,
  output ssa_pkg::decode_t                 dec,
  output logic        [ADDR_W-1:0]         addr
);

  logic [31:0] seg_lim;
  logic [31:0] col_lim;
  logic        seg_bad;
  logic        col_bad;

  // Effective limits saturate at the table dimensions.
  assign seg_lim = (32'(seg_count) < 32'(MAX_SEGMENTS)) ? 32'(seg_count)
                                                        : 32'(MAX_SEGMENTS);
  assign col_lim = (32'(row_width) < 32'(MAX_ROW_WIDTH)) ? 32'(row_width)
                                                         : 32'(MAX_ROW_WIDTH);

  assign seg_bad = segment_id[ssa_pkg::SEG_W-1] || ($unsigned(segment_id) >= seg_lim);
  assign col_bad = 32'(column) >= col_lim;

  assign addr = ADDR_W'(ADDR_W'($unsigned(segment_id)) * ADDR_W'(MAX_ROW_WIDTH)
                        + ADDR_W'(column));

  always_comb begin
    dec.cmd    = cmd;
    dec.status = ssa_pkg::ST_OK;
    if (cmd == ssa_pkg::CMD_ACC || cmd == ssa_pkg::CMD_READ) begin
      if (seg_bad) begin
        dec.status = ssa_pkg::ST_SEG_ERR;
      end else if (col_bad) begin
        dec.status = ssa_pkg::ST_COL_ERR;
      end
    end
  end

endmodule

// ===== design/ssa_table.sv =====
// Sum table memory: one write port, one registered read port, zeroing sweep.
// Sweeps after reset and on each clear; busy stays high until the sweep has zeroed every entry.
module ssa_table #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear_start,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data,
  output logic                  busy
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]     sweep_addr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;

  always_comb begin
    mem_we = wr_en;
    mem_wa = wr_addr;
    mem_wd = wr_data;
    if (busy) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr;
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (clear_start) begin
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      if (sweep_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      sweep_addr <= sweep_addr + ADDR_W'(1);
    end
  end

endmodule

// ===== design/segment_sum_accumulator.sv =====
// Scatter-add accumulator over a table of MAX_SEGMENTS x MAX_ROW_WIDTH signed sums. Commands
// arrive as beats on req and each gives exactly one result beat on rsp, through stage 1 and the
// output register. Accumulate and read run at one beat per cycle while rsp does not stall: the
// entry is read from the table port at acceptance and written back as the beat leaves stage 1,
// and a back-to-back hit on the same entry is forwarded from the adder. A clear zeroes the table
// with a sweep of one entry per cycle; req.ready stays low until the sweep ends, and likewise
// after reset. Write seg_count and row_width only while the block is idle.
module segment_sum_accumulator #(
  parameter int MAX_SEGMENTS  = 16,
  parameter int MAX_ROW_WIDTH = 16,
  parameter int DATA_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssa_pkg::CFG_W-1:0]           cfg_wdata,
  ssa_req_if.sink                             req,
  ssa_rsp_if.source                           rsp
);

  localparam int DEPTH  = MAX_SEGMENTS * MAX_ROW_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ssa_pkg::CFG_W-1:0] seg_count;
  logic [ssa_pkg::CFG_W-1:0] row_width;

  ssa_pkg::decode_t      dec;
  logic [ADDR_W-1:0]     dec_addr;
  logic                  accept;

  logic                  s1_valid;
  ssa_pkg::decode_t      s1_dec;
  logic [ADDR_W-1:0]     s1_addr;
  logic [DATA_WIDTH-1:0] s1_value;
  logic                  byp_sel;
  logic [DATA_WIDTH-1:0] byp_data;
  logic                  s1_adv;
  logic                  s1_ok;
  logic                  s1_wr;
  logic                  s1_clear;

  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] old_sum;
  logic [DATA_WIDTH-1:0] new_sum;
  logic                  busy;

  logic                  sticky;
  logic                  sticky_next;
  logic [DATA_WIDTH-1:0] res_sum_next;

  logic                  out_valid;
  logic [ssa_pkg::SUM_W-1:0]    out_sum;
  logic [ssa_pkg::STATUS_W-1:0] out_status;
  logic                  out_err;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= ssa_pkg::SEG_COUNT_RST;
      row_width <= ssa_pkg::ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssa_pkg::CFG_SEG_COUNT: seg_count <= cfg_wdata;
        ssa_pkg::CFG_ROW_WIDTH: row_width <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ssa_decode #(
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_decode (
    .cmd          (req.cmd),
    .segment_id   (req.segment_id),
    .column       (req.column),
    .seg_count    (seg_count),
    .row_width    (row_width),
    .dec          (dec),
    .addr         (dec_addr)
  );

  assign s1_ok    = s1_dec.status == ssa_pkg::ST_OK;
  assign s1_clear = s1_dec.cmd == ssa_pkg::CMD_CLEAR;
  assign s1_wr    = s1_dec.cmd == ssa_pkg::CMD_ACC && s1_ok;
  assign s1_adv   = s1_valid && (!out_valid || rsp.ready);

  // Hold off new beats while clearing, while a clear is about to start the sweep, or while stage 1 is stalled.
  assign req.ready = !busy && (!s1_valid || (s1_adv && !s1_clear));
  assign accept    = req.valid && req.ready;

  ssa_table #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .clear_start (s1_adv && s1_clear),
    .rd_en       (accept),
    .rd_addr     (dec_addr),
    .wr_en       (s1_adv && s1_wr),
    .wr_addr     (s1_addr),
    .wr_data     (new_sum),
    .rd_data     (rd_data),
    .busy        (busy)
  );

  assign old_sum = byp_sel ? byp_data : rd_data;
  assign new_sum = old_sum + s1_value;

  always_comb begin
    res_sum_next = '0;
    if (s1_ok && s1_dec.cmd == ssa_pkg::CMD_ACC) begin
      res_sum_next = new_sum;
    end else if (s1_ok && s1_dec.cmd == ssa_pkg::CMD_READ) begin
      res_sum_next = old_sum;
    end
  end

  always_comb begin
    sticky_next = sticky;
    if (s1_clear) begin
      sticky_next = 1'b0;
    end else if (!s1_ok) begin
      sticky_next = 1'b1;
    end
  end

  // Stage 1 payload; the bypass catches a write to the same entry at the accepting edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dec   <= dec;
      s1_addr  <= dec_addr;
      s1_value <= DATA_WIDTH'(req.value);
      byp_sel  <= s1_adv && s1_wr && (s1_addr == dec_addr);
      byp_data <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum    <= ssa_pkg::SUM_W'(res_sum_next);
      out_status <= s1_dec.status;
      out_err    <= sticky_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      sticky    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        sticky    <= sticky_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.sum        = out_sum;
  assign rsp.status     = out_status;
  assign rsp.error_seen = out_err;

endmodule

// ===== design/ssa_checker.sv =====
// Port-level checks for the segment sum accumulator, bound to its top level.
// Depends on ssa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ssa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ssa_pkg::SUM_W-1:0]    rsp_sum,
  input logic [ssa_pkg::STATUS_W-1:0] rsp_status,
  input logic                         rsp_error_seen
);

  logic err_beat;

  assign err_beat = rsp_valid && (rsp_status != ssa_pkg::ST_OK);

  // An error result always shows the sticky flag set.
  `ASSERT_IMPLIES(a_err_sticky, clk, rst, err_beat, rsp_error_seen)

  // An error result carries no sum.
  `ASSERT_IMPLIES(a_err_zero, clk, rst, err_beat, rsp_sum == '0)

  // The zeroing sweep blocks input right after reset.
  `ASSERT_IMPLIES(a_sweep_after_rst, clk, 1'b0, $fell(rst), !req_ready)

  // A stalled result beat holds.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sum))

endmodule

bind segment_sum_accumulator ssa_checker u_ssa_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_sum        (rsp.sum),
  .rsp_status     (rsp.status),
  .rsp_error_seen (rsp.error_seen)
);

// ===== dv/segment_sum_accumulator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for segment_sum_accumulator: directed and random command beats,
// a scoreboard fed by a table-of-sums predictor, random bursts and stalls on both channels.
// Depends on ssa_pkg and the ssa_req_if / ssa_rsp_if interfaces of the design.
module segment_sum_accumulator_tb;

  localparam int MAX_SEG        = 16;
  localparam int MAX_COL        = 16;
  localparam int TABLE_DEPTH    = MAX_SEG * MAX_COL;
  localparam int IDLE_LIMIT     = 4000;
  localparam int HOLDOFF_CYCLES = 120;
  localparam int NUM_SETTINGS   = 9;
  localparam int REPORT_MAX     = 10;

  localparam logic [ssa_pkg::CFG_W-1:0] SEG_SETTINGS [NUM_SETTINGS] =
    '{5'd16, 5'd1, 5'd0, 5'd16, 5'd31, 5'd5, 5'd17, 5'd2, 5'd12};
  localparam logic [ssa_pkg::CFG_W-1:0] COL_SETTINGS [NUM_SETTINGS] =
    '{5'd16, 5'd1, 5'd16, 5'd0, 5'd31, 5'd9, 5'd3, 5'd16, 5'd20};

  typedef struct {
    ssa_pkg::cmd_t             cmd;
    logic [ssa_pkg::SEG_W-1:0] seg;
    logic [ssa_pkg::COL_W-1:0] col;
    logic [ssa_pkg::VAL_W-1:0] val;
  } command_t;

  typedef struct packed {
    logic [ssa_pkg::SUM_W-1:0] sum;
    ssa_pkg::status_t          status;
    logic                      error_seen;
  } result_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ssa_pkg::CFG_W-1:0]     cfg_wdata = '0;

  ssa_req_if req ();
  ssa_rsp_if rsp ();

  segment_sum_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [ssa_pkg::SUM_W-1:0] entry_sums [TABLE_DEPTH];
  logic                      error_flag    = 1'b0;
  logic [ssa_pkg::CFG_W-1:0] seg_count_cfg = ssa_pkg::SEG_COUNT_RST;
  logic [ssa_pkg::CFG_W-1:0] row_width_cfg = ssa_pkg::ROW_WIDTH_RST;

  command_t    pending_cmds [$];
  result_t     expected_results [$];
  int unsigned cmds_queued     = 0;
  int unsigned cmds_taken      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned acc_count       = 0;
  int unsigned read_count      = 0;
  int unsigned clear_count     = 0;
  int unsigned range_errors    = 0;
  int unsigned settings_run    = 0;
  logic [ssa_pkg::SEG_W-1:0] last_seg = '0;
  logic [ssa_pkg::COL_W-1:0] last_col = '0;

  function automatic int unsigned seg_limit();
    return (seg_count_cfg < MAX_SEG) ? seg_count_cfg : MAX_SEG;
  endfunction

  function automatic int unsigned col_limit();
    return (row_width_cfg < MAX_COL) ? row_width_cfg : MAX_COL;
  endfunction

  function automatic result_t apply_command(command_t c);
    result_t     r;
    int unsigned idx;
    r.sum    = '0;
    r.status = ssa_pkg::ST_OK;
    case (c.cmd)
      ssa_pkg::CMD_CLEAR: begin
        foreach (entry_sums[i]) entry_sums[i] = '0;
        error_flag = 1'b0;
      end
      ssa_pkg::CMD_ACC, ssa_pkg::CMD_READ: begin
        // segment check wins over column check
        if (c.seg[ssa_pkg::SEG_W-1] || c.seg >= seg_limit()) begin
          r.status   = ssa_pkg::ST_SEG_ERR;
          error_flag = 1'b1;
        end else if (c.col >= col_limit()) begin
          r.status   = ssa_pkg::ST_COL_ERR;
          error_flag = 1'b1;
        end else begin
          idx = c.seg * MAX_COL + c.col;
          if (c.cmd == ssa_pkg::CMD_ACC) entry_sums[idx] = entry_sums[idx] + c.val;
          r.sum = entry_sums[idx];
        end
      end
      default: ;
    endcase
    r.error_seen = error_flag;
    return r;
  endfunction

  function automatic logic [ssa_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return ssa_pkg::VAL_W'($urandom_range(0, 15));
      3:       return -ssa_pkg::VAL_W'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int unsigned pick;
    int unsigned kind;
    int unsigned slim;
    int unsigned clim;
    slim  = seg_limit();
    clim  = col_limit();
    pick  = $urandom_range(0, 999);
    kind  = $urandom_range(0, 99);
    c.seg = $urandom;
    c.col = ssa_pkg::COL_W'($urandom);
    c.val = random_value();
    if (pick < 15) begin
      c.cmd = ssa_pkg::CMD_CLEAR;
    end else if (pick < 45) begin
      c.cmd = ssa_pkg::CMD_NOP;
    end else begin
      c.cmd = (pick < 700) ? ssa_pkg::CMD_ACC : ssa_pkg::CMD_READ;
      if (kind < 8 || slim == 0) begin
        case ($urandom_range(0, 3))
          0:       c.seg = slim;
          1:       c.seg = $urandom_range(slim, 255);
          2:       c.seg = {1'b1, 31'($urandom)};
          default: ;
        endcase
      end else if (kind < 14 || clim == 0) begin
        c.seg = $urandom_range(0, slim - 1);
        c.col = ssa_pkg::COL_W'($urandom_range(clim, 255));
      end else if (kind < 44) begin
        // hit the previous entry again to exercise forwarding
        c.seg = last_seg;
        c.col = last_col;
      end else begin
        c.seg = $urandom_range(0, slim - 1);
        c.col = ssa_pkg::COL_W'($urandom_range(0, clim - 1));
      end
      last_seg = c.seg;
      last_col = c.col;
    end
    return c;
  endfunction

  function automatic void queue_cmd(ssa_pkg::cmd_t cmd, logic [ssa_pkg::SEG_W-1:0] seg,
                                    logic [ssa_pkg::COL_W-1:0] col,
                                    logic [ssa_pkg::VAL_W-1:0] val);
    command_t c;
    c.cmd = cmd;
    c.seg = seg;
    c.col = col;
    c.val = val;
    pending_cmds.push_back(c);
    cmds_queued++;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  task automatic write_reg(logic [ssa_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssa_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ssa_pkg::CFG_SEG_COUNT) seg_count_cfg = data;
    else row_width_cfg = data;
  endtask

  // Wait for every beat to drain, then let a full clear sweep run out.
  task automatic settle();
    wait (cmds_taken == cmds_queued && expected_results.size() == 0);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  // Sender: bursts of random length, random gaps in between
  command_t    drive_cmd;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req.valid      <= 1'b0;
      req.cmd        <= ssa_pkg::CMD_NOP;
      req.segment_id <= '0;
      req.column     <= '0;
      req.value      <= '0;
    end else if (!req.valid || req.ready) begin
      if (gap_left != 0) begin
        req.valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        drive_cmd = pending_cmds.pop_front();
        req.valid      <= 1'b1;
        req.cmd        <= drive_cmd.cmd;
        req.segment_id <= drive_cmd.seg;
        req.column     <= drive_cmd.col;
        req.value      <= drive_cmd.val;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall pattern plus two long hold-offs
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  pattern_pos   = '0;
  int unsigned holdoff_left  = 0;
  int unsigned holdoffs_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      pattern_pos <= pattern_pos + 4'd1;
      if (pattern_pos == 4'hF)
        stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                         (16'($urandom) | 16'($urandom));
      if (holdoff_left != 0) begin
        rsp.ready    <= 1'b0;
        holdoff_left <= holdoff_left - 1;
      end else if (holdoffs_done < 2 && results_checked >= 300 + 700 * holdoffs_done) begin
        rsp.ready     <= 1'b0;
        holdoff_left  <= HOLDOFF_CYCLES;
        holdoffs_done <= holdoffs_done + 1;
      end else begin
        rsp.ready <= stall_pattern[pattern_pos];
      end
    end
  end

  // Monitor and scoreboard
  command_t seen_cmd;
  result_t  want;
  result_t  got;

  always @(posedge clk) begin
    if (rst) begin
      foreach (entry_sums[i]) entry_sums[i] = '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.sum        = rsp.sum;
        got.status     = ssa_pkg::status_t'(rsp.status);
        got.error_seen = rsp.error_seen;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result beat sum=%h status=%0d err=%0b with nothing pending",
                               got.sum, got.status, got.error_seen));
        end else begin
          want = expected_results.pop_front();
          if (got.sum !== want.sum || got.status !== want.status ||
              got.error_seen !== want.error_seen)
            flag_error($sformatf({"beat %0d: expected sum=%h status=%0d err=%0b, ",
                                  "got sum=%h status=%0d err=%0b"},
                                 results_checked, want.sum, want.status, want.error_seen,
                                 got.sum, got.status, got.error_seen));
        end
        results_checked++;
      end
      if (req.valid && req.ready) begin
        seen_cmd.cmd = req.cmd;
        seen_cmd.seg = req.segment_id;
        seen_cmd.col = req.column;
        seen_cmd.val = req.value;
        want = apply_command(seen_cmd);
        expected_results.push_back(want);
        cmds_taken++;
        if (seen_cmd.cmd == ssa_pkg::CMD_ACC) acc_count++;
        if (seen_cmd.cmd == ssa_pkg::CMD_READ) read_count++;
        if (seen_cmd.cmd == ssa_pkg::CMD_CLEAR) clear_count++;
        if (want.status != ssa_pkg::ST_OK) range_errors++;
      end
    end
  end

  // Watchdog: no beat on either channel for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%t watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_items;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: wraparound, range errors, no-op, clear, back-to-back hits
    queue_cmd(ssa_pkg::CMD_READ,  32'd0,         8'd0,   32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd0,         8'd0,   32'h7FFF_FFFF);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd0,         8'd0,   32'd1);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd0,         8'd0,   32'h8000_0000);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd15,        8'd15,  32'hFFFF_FFFF);
    queue_cmd(ssa_pkg::CMD_READ,  32'd15,        8'd15,  32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'hFFFF_FFFF, 8'd0,   32'd5);
    queue_cmd(ssa_pkg::CMD_READ,  32'h8000_0000, 8'd0,   32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'h7FFF_FFFF, 8'd3,   32'd1);
    queue_cmd(ssa_pkg::CMD_READ,  32'd16,        8'd0,   32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd3,         8'd16,  32'd9);
    queue_cmd(ssa_pkg::CMD_READ,  32'd3,         8'd255, 32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd16,        8'd255, 32'd2);
    queue_cmd(ssa_pkg::CMD_NOP,   32'd0,         8'd0,   32'd5);
    queue_cmd(ssa_pkg::CMD_NOP,   32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    queue_cmd(ssa_pkg::CMD_CLEAR, 32'd0,         8'd0,   32'd0);
    queue_cmd(ssa_pkg::CMD_READ,  32'd15,        8'd15,  32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd7,         8'd7,   32'h1234_5678);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd7,         8'd7,   32'h1234_5678);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd7,         8'd7,   32'hFFFF_FFFF);
    queue_cmd(ssa_pkg::CMD_READ,  32'd7,         8'd7,   32'd0);
    queue_cmd(ssa_pkg::CMD_ACC,   32'd7,         8'd8,   32'h8000_0000);
    settle();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_reg(ssa_pkg::CFG_SEG_COUNT, SEG_SETTINGS[p]);
      write_reg(ssa_pkg::CFG_ROW_WIDTH, COL_SETTINGS[p]);
      settings_run++;
      // with either limit at zero every access is an error; keep those phases short
      phase_items = (seg_limit() == 0 || col_limit() == 0) ? 40 : 220;
      repeat (phase_items) begin
        pending_cmds.push_back(random_command());
        cmds_queued++;
      end
      settle();
    end

    $display("Covered %0d commands over %0d register settings: %0d accumulates, %0d reads, %s",
             cmds_taken, settings_run, acc_count, read_count,
             $sformatf("%0d clears.", clear_count));
    $display("%0d range errors predicted, %0d results checked, %0d mismatches, %s",
             range_errors, results_checked, mismatches,
             $sformatf("%0d long hold-offs.", holdoffs_done));
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== segment_sum_accumulator.f =====
+incdir+design
design/ssa_pkg.sv
design/ssa_if.sv
design/ssa_decode.sv
design/ssa_table.sv
design/segment_sum_accumulator.sv
design/ssa_checker.sv
dv/segment_sum_accumulator_tb.sv
